@@ rtl/rv64_pkg.sv @@
// Shared types, codes and helper functions of the RV64IM execute unit.
// No dependencies; used by the top level, rv64_ctrl, rv64_mdu, rv64_dp and rv64_chk.
package rv64_pkg;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMMW = 7'h1b;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPW    = 7'h3b;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INST_EBREAK = 32'h0010_0073;

  localparam logic [4:0] REG_HALT = 5'd10;

  localparam logic ITEM_EXEC      = 1'b0;
  localparam logic ITEM_LOAD_DATA = 1'b1;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_ECALL   = 2'd1;
  localparam logic [1:0] ST_BREAK   = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  typedef enum logic [2:0] {
    C_IDLE,
    C_FETCH,
    C_EXEC,
    C_MDWAIT,
    C_WRITE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_MULFIX,
    MD_DIV,
    MD_DIVFIX
  } md_phase_e;

  typedef struct packed {
    logic accept;
    logic latch_ops;
    logic exec;
    logic md_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic md_req;
    logic md_done;
  } dp_status_t;

  function automatic logic [63:0] sext_word(input logic [63:0] v);
    sext_word = {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] size_mask(input logic [1:0] code);
    case (code)
      2'd0:    size_mask = 64'h0000_0000_0000_00ff;
      2'd1:    size_mask = 64'h0000_0000_0000_ffff;
      2'd2:    size_mask = 64'h0000_0000_ffff_ffff;
      default: size_mask = '1;
    endcase
  endfunction

  function automatic logic [63:0] ext_load(input logic [63:0] d, input logic [1:0] code,
                                           input logic sgn);
    case (code)
      2'd0:    ext_load = {{56{sgn & d[7]}}, d[7:0]};
      2'd1:    ext_load = {{48{sgn & d[15]}}, d[15:0]};
      2'd2:    ext_load = {{32{sgn & d[31]}}, d[31:0]};
      default: ext_load = d;
    endcase
  endfunction

endpackage

@@ rtl/rv64_if.sv @@
// Valid/ready channel interfaces for instruction items and result items.
// No dependencies.
interface rv64_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction;
  logic [63:0] pc;
  logic [63:0] load_data;

  modport source (output valid, operation, instruction, pc, load_data, input ready);
  modport sink   (input valid, operation, instruction, pc, load_data, output ready);
endinterface

interface rv64_out_if;
  logic               valid;
  logic               ready;
  logic        [63:0] next_pc;
  logic        [1:0]  mem_request;
  logic        [63:0] mem_address;
  logic        [3:0]  mem_bytes;
  logic        [63:0] mem_write_data;
  logic        [1:0]  status;
  logic signed [63:0] halt_code;

  modport source (output valid, next_pc, mem_request, mem_address, mem_bytes, mem_write_data,
                  status, halt_code, input ready);
  modport sink   (input valid, next_pc, mem_request, mem_address, mem_bytes, mem_write_data,
                  status, halt_code, output ready);
endinterface

@@ rtl/rv64im_execute_unit.sv @@
// Top level of the RV64IM execute unit: controller, datapath and the channel interfaces.
// Depends on rv64_pkg, rv64_if, rv64_ctrl and rv64_dp.
//
// One item is in flight at a time. An item is taken in the idle state; a plain instruction or a
// load-data item passes through register file read, operand latch and execute, and its result is
// then committed into the output register, after which the next item can be taken. Multiply
// instructions also pass through the shared multiply/divide unit (four 32x32 partial products and
// a correction), divide and remainder through its restoring divider (one quotient bit a cycle).
// The result sits in an output register, so a stalled result holds the unit only at its commit
// step. The register file reads as zero after reset with no clearing pass.
module rv64im_execute_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rv64_in_if.sink    in_ch,
  rv64_out_if.source out_ch
);

  rv64_pkg::dp_cmd_t    cmd;
  rv64_pkg::dp_status_t dp_status;

  rv64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  rv64_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .operation_i      (in_ch.operation),
    .instruction_i    (in_ch.instruction),
    .pc_i             (in_ch.pc),
    .load_data_i      (in_ch.load_data),
    .next_pc_o        (out_ch.next_pc),
    .mem_request_o    (out_ch.mem_request),
    .mem_address_o    (out_ch.mem_address),
    .mem_bytes_o      (out_ch.mem_bytes),
    .mem_write_data_o (out_ch.mem_write_data),
    .result_status_o  (out_ch.status),
    .halt_code_o      (out_ch.halt_code)
  );

endmodule

@@ rtl/rv64_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module rv64_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

@@ rtl/rv64_ctrl.sv @@
// Controller of the execute unit: sequences fetch, execute, multiply/divide wait and commit.
// Depends on rv64_pkg.
module rv64_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  rv64_pkg::dp_status_t status_i,
  output rv64_pkg::dp_cmd_t    cmd_o
);

  rv64_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rv64_pkg::C_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rv64_pkg::C_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = rv64_pkg::C_FETCH;
        end
      end
      rv64_pkg::C_FETCH: begin
        cmd_o.latch_ops = 1'b1;
        state_d         = rv64_pkg::C_EXEC;
      end
      rv64_pkg::C_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.md_start = status_i.md_req;
        state_d        = status_i.md_req ? rv64_pkg::C_MDWAIT : rv64_pkg::C_WRITE;
      end
      rv64_pkg::C_MDWAIT: begin
        if (status_i.md_done) begin
          state_d = rv64_pkg::C_WRITE;
        end
      end
      rv64_pkg::C_WRITE: begin
        cmd_o.commit = !out_valid_q || out_ready_i;
        if (cmd_o.commit) begin
          state_d = rv64_pkg::C_IDLE;
        end
      end
      default: state_d = rv64_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/rv64_mdu.sv @@
// Shared multiply/divide unit: multiply by 32x32 partial products, restoring divide
// one quotient bit a cycle. Depends on rv64_pkg.
module rv64_mdu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  func_i,
  input  logic        word_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  rv64_pkg::md_phase_e phase_q, phase_d;
  logic [5:0]   cnt_q;
  logic         done_q;
  logic [2:0]   func_q;
  logic         word_q;
  logic [63:0]  ma_q, mb_q, corr_q;
  logic [127:0] acc_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [63:0]  quo_q, rem_q, dvs_q, orig_q;
  logic         neg_q_q, neg_r_q, dz_q;
  logic [63:0]  res_q;

  logic [63:0]  oa, ob;
  logic         sgn, na, nb;
  logic [31:0]  ah, bh;
  logic [127:0] pp_sh;
  logic [64:0]  rem_sh, diff;
  logic [63:0]  fix;

  always_comb begin
    oa = a_i;
    ob = b_i;
    if (word_i) begin
      if (func_i == 3'd4 || func_i == 3'd6) begin
        oa = rv64_pkg::sext_word(a_i);
        ob = rv64_pkg::sext_word(b_i);
      end else begin
        oa = {32'd0, a_i[31:0]};
        ob = {32'd0, b_i[31:0]};
      end
    end
    sgn = !func_i[0];
    na  = sgn && oa[63];
    nb  = sgn && ob[63];
  end

  always_comb begin
    ah = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    bh = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    case (sh_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd1:    pp_sh = {32'd0, pp_q, 32'd0};
      default: pp_sh = {pp_q, 64'd0};
    endcase
    rem_sh = {rem_q, quo_q[63]};
    diff   = rem_sh - {1'b0, dvs_q};
  end

  always_comb begin
    fix = '0;
    if (phase_q == rv64_pkg::MD_MULFIX) begin
      fix = (func_q == 3'd0) ? acc_q[63:0] : acc_q[127:64] - corr_q;
    end else if (dz_q) begin
      fix = func_q[1] ? orig_q : '1;
    end else if (func_q[1]) begin
      fix = neg_r_q ? 64'd0 - rem_q : rem_q;
    end else begin
      fix = neg_q_q ? 64'd0 - quo_q : quo_q;
    end
    if (word_q) begin
      fix = rv64_pkg::sext_word(fix);
    end
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      rv64_pkg::MD_IDLE: begin
        if (start_i) begin
          phase_d = func_i[2] ? rv64_pkg::MD_DIV : rv64_pkg::MD_MUL;
        end
      end
      rv64_pkg::MD_MUL:    if (cnt_q == 6'd4) phase_d = rv64_pkg::MD_MULFIX;
      rv64_pkg::MD_MULFIX: phase_d = rv64_pkg::MD_IDLE;
      rv64_pkg::MD_DIV:    if (cnt_q == 6'd63) phase_d = rv64_pkg::MD_DIVFIX;
      rv64_pkg::MD_DIVFIX: phase_d = rv64_pkg::MD_IDLE;
      default:             phase_d = rv64_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rv64_pkg::MD_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == rv64_pkg::MD_MULFIX) || (phase_q == rv64_pkg::MD_DIVFIX);
      if (phase_q == rv64_pkg::MD_IDLE) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == rv64_pkg::MD_IDLE && start_i) begin
      func_q  <= func_i;
      word_q  <= word_i;
      acc_q   <= '0;
      orig_q  <= oa;
      rem_q   <= '0;
      neg_q_q <= na ^ nb;
      neg_r_q <= na;
      dz_q    <= (ob == 64'd0);
      if (func_i[2]) begin
        quo_q <= na ? 64'd0 - oa : oa;
        dvs_q <= nb ? 64'd0 - ob : ob;
      end else begin
        ma_q <= oa;
        mb_q <= ob;
        case (func_i[1:0])
          2'd1:    corr_q <= (oa[63] ? ob : 64'd0) + (ob[63] ? oa : 64'd0);
          2'd2:    corr_q <= oa[63] ? ob : 64'd0;
          default: corr_q <= '0;
        endcase
      end
    end
    if (phase_q == rv64_pkg::MD_MUL) begin
      if (cnt_q != 6'd4) begin
        pp_q <= ah * bh;
        sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (cnt_q != 6'd0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
    if (phase_q == rv64_pkg::MD_DIV) begin
      if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
    if (phase_q == rv64_pkg::MD_MULFIX || phase_q == rv64_pkg::MD_DIVFIX) begin
      res_q <= fix;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/rv64_dp.sv @@
// Datapath of the execute unit: register file, decode, ALU, branch and memory fields,
// load tracking and the result register. Depends on rv64_pkg, rv64_ram and rv64_mdu.
module rv64_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rv64_pkg::dp_cmd_t    cmd_i,
  output rv64_pkg::dp_status_t status_o,
  input  logic                 operation_i,
  input  logic [31:0]          instruction_i,
  input  logic [63:0]          pc_i,
  input  logic [63:0]          load_data_i,
  output logic [63:0]          next_pc_o,
  output logic [1:0]           mem_request_o,
  output logic [63:0]          mem_address_o,
  output logic [3:0]           mem_bytes_o,
  output logic [63:0]          mem_write_data_o,
  output logic [1:0]           result_status_o,
  output logic signed [63:0]   halt_code_o
);

  logic        op_q;
  logic [31:0] ins_q;
  logic [63:0] pc_q, ldata_q, a_q, b_q;
  logic [4:0]  ra_q, rb_q;
  logic [31:0] valid_q;
  logic        lp_q, ld_sext_q;
  logic [4:0]  ld_dest_q;
  logic [1:0]  ld_size_q;

  logic [63:0] nxt_q, addr_q, wdata_q, hc_q, res_q;
  logic [1:0]  req_q, stat_q;
  logic [3:0]  bytes_q;
  logic        wr_q;
  logic [4:0]  wd_q;

  logic [63:0] rd_a, rd_b;
  logic [4:0]  ra_d;
  logic        md_done;
  logic [63:0] md_res;

  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j, pc4;
  logic [63:0] alu_b, alu, w_b, wsum;
  logic        alu_alt, w_sub, take;
  logic [5:0]  sh;
  logic [4:0]  wsh;
  logic [31:0] wsll, wsrl, wsra;

  logic [63:0] nxt, addr, wdata, hc, res;
  logic [1:0]  req, stat;
  logic [3:0]  bytes;
  logic        wr, ill, md_req, lp_set;
  logic [4:0]  wd;

  assign ra_d = (instruction_i == rv64_pkg::INST_EBREAK) ? rv64_pkg::REG_HALT
                                                          : instruction_i[19:15];

  rv64_ram #(
    .Width(64),
    .Depth(32)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (cmd_i.commit && wr_q),
    .waddr_i   (wd_q),
    .wdata_i   (res_q),
    .re_i      (cmd_i.accept),
    .raddr_a_i (ra_d),
    .raddr_b_i (instruction_i[24:20]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  rv64_mdu u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .func_i   (f3),
    .word_i   (opc == rv64_pkg::OPC_OPW),
    .a_i      (a_q),
    .b_i      (b_q),
    .done_o   (md_done),
    .result_o (md_res)
  );

  always_comb begin
    opc   = ins_q[6:0];
    rd    = ins_q[11:7];
    f3    = ins_q[14:12];
    f7    = ins_q[31:25];
    imm_i = {{52{ins_q[31]}}, ins_q[31:20]};
    imm_s = {{52{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
    imm_b = {{51{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
    imm_u = {{32{ins_q[31]}}, ins_q[31:12], 12'd0};
    imm_j = {{43{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
    pc4   = pc_q + 64'd4;

    alu_b   = (opc == rv64_pkg::OPC_OP) ? b_q : imm_i;
    alu_alt = (opc == rv64_pkg::OPC_OP) ? (f7 == rv64_pkg::F7_ALT)
                                        : ((f3 == 3'd5) && ins_q[30]);
    sh      = alu_b[5:0];
    case (f3)
      3'd0:    alu = alu_alt ? a_q - alu_b : a_q + alu_b;
      3'd1:    alu = a_q << sh;
      3'd2:    alu = {63'd0, $signed(a_q) < $signed(alu_b)};
      3'd3:    alu = {63'd0, a_q < alu_b};
      3'd4:    alu = a_q ^ alu_b;
      3'd5:    alu = alu_alt ? 64'($signed(a_q) >>> sh) : a_q >> sh;
      3'd6:    alu = a_q | alu_b;
      default: alu = a_q & alu_b;
    endcase

    w_b   = (opc == rv64_pkg::OPC_OPW) ? b_q : imm_i;
    w_sub = (opc == rv64_pkg::OPC_OPW) && (f7 == rv64_pkg::F7_ALT);
    wsum  = w_sub ? a_q - w_b : a_q + w_b;
    wsh   = w_b[4:0];
    wsll  = a_q[31:0] << wsh;
    wsrl  = a_q[31:0] >> wsh;
    wsra  = 32'($signed(a_q[31:0]) >>> wsh);

    case (f3)
      3'd0:    take = (a_q == b_q);
      3'd1:    take = (a_q != b_q);
      3'd4:    take = $signed(a_q) < $signed(b_q);
      3'd5:    take = !($signed(a_q) < $signed(b_q));
      3'd6:    take = a_q < b_q;
      default: take = !(a_q < b_q);
    endcase
  end

  always_comb begin
    nxt    = pc4;
    req    = rv64_pkg::MEM_NONE;
    addr   = '0;
    bytes  = '0;
    wdata  = '0;
    stat   = rv64_pkg::ST_NORMAL;
    hc     = '0;
    res    = '0;
    wr     = 1'b0;
    wd     = rd;
    ill    = 1'b0;
    md_req = 1'b0;
    lp_set = 1'b0;
    case (opc)
      rv64_pkg::OPC_LOAD: begin
        if (f3 == 3'd7) begin
          ill = 1'b1;
        end else begin
          req    = rv64_pkg::MEM_LOAD;
          addr   = a_q + imm_i;
          bytes  = 4'd1 << f3[1:0];
          lp_set = 1'b1;
        end
      end
      rv64_pkg::OPC_STORE: begin
        if (f3[2]) begin
          ill = 1'b1;
        end else begin
          req   = rv64_pkg::MEM_STORE;
          addr  = a_q + imm_s;
          bytes = 4'd1 << f3[1:0];
          wdata = b_q & rv64_pkg::size_mask(f3[1:0]);
        end
      end
      rv64_pkg::OPC_OPIMM: begin
        res = alu;
        if (f3 == 3'd1) begin
          ill = (ins_q[31:26] != 6'd0);
        end else if (f3 == 3'd5) begin
          ill = (ins_q[31:26] != 6'd0) && (ins_q[31:26] != 6'h10);
        end
        wr = 1'b1;
      end
      rv64_pkg::OPC_OPIMMW: begin
        wr = 1'b1;
        if (f3 == 3'd0) begin
          res = rv64_pkg::sext_word(wsum);
        end else if (f3 == 3'd1 && f7 == rv64_pkg::F7_BASE) begin
          res = {{32{wsll[31]}}, wsll};
        end else if (f3 == 3'd5 && f7 == rv64_pkg::F7_BASE) begin
          res = {{32{wsrl[31]}}, wsrl};
        end else if (f3 == 3'd5 && f7 == rv64_pkg::F7_ALT) begin
          res = {{32{wsra[31]}}, wsra};
        end else begin
          ill = 1'b1;
        end
      end
      rv64_pkg::OPC_OP: begin
        wr  = 1'b1;
        res = alu;
        if (f7 == rv64_pkg::F7_MULDIV) begin
          md_req = 1'b1;
        end else if (!(f7 == rv64_pkg::F7_BASE ||
                       (f7 == rv64_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))) begin
          ill = 1'b1;
        end
      end
      rv64_pkg::OPC_OPW: begin
        wr = 1'b1;
        if (f7 == rv64_pkg::F7_MULDIV) begin
          md_req = (f3 == 3'd0) || f3[2];
          ill    = !md_req;
        end else if (f7 == rv64_pkg::F7_BASE && f3 == 3'd0) begin
          res = rv64_pkg::sext_word(wsum);
        end else if (f7 == rv64_pkg::F7_ALT && f3 == 3'd0) begin
          res = rv64_pkg::sext_word(wsum);
        end else if (f7 == rv64_pkg::F7_BASE && f3 == 3'd1) begin
          res = {{32{wsll[31]}}, wsll};
        end else if (f7 == rv64_pkg::F7_BASE && f3 == 3'd5) begin
          res = {{32{wsrl[31]}}, wsrl};
        end else if (f7 == rv64_pkg::F7_ALT && f3 == 3'd5) begin
          res = {{32{wsra[31]}}, wsra};
        end else begin
          ill = 1'b1;
        end
      end
      rv64_pkg::OPC_BRANCH: begin
        if (f3 == 3'd2 || f3 == 3'd3) begin
          ill = 1'b1;
        end else if (take) begin
          nxt = pc_q + imm_b;
        end
      end
      rv64_pkg::OPC_JAL: begin
        res = pc4;
        wr  = 1'b1;
        nxt = pc_q + imm_j;
      end
      rv64_pkg::OPC_JALR: begin
        if (f3 != 3'd0) begin
          ill = 1'b1;
        end else begin
          res = pc4;
          wr  = 1'b1;
          nxt = (a_q + imm_i) & ~64'd1;
        end
      end
      rv64_pkg::OPC_LUI: begin
        res = imm_u;
        wr  = 1'b1;
      end
      rv64_pkg::OPC_AUIPC: begin
        res = pc_q + imm_u;
        wr  = 1'b1;
      end
      rv64_pkg::OPC_SYSTEM: begin
        if (ins_q == rv64_pkg::INST_ECALL) begin
          stat = rv64_pkg::ST_ECALL;
        end else if (ins_q == rv64_pkg::INST_EBREAK) begin
          stat = rv64_pkg::ST_BREAK;
          hc   = a_q;
        end else begin
          ill = 1'b1;
        end
      end
      default: ill = 1'b1;
    endcase

    if (ill) begin
      stat   = rv64_pkg::ST_ILLEGAL;
      hc     = '1;
      wr     = 1'b0;
      req    = rv64_pkg::MEM_NONE;
      addr   = '0;
      bytes  = '0;
      wdata  = '0;
      lp_set = 1'b0;
      md_req = 1'b0;
      nxt    = pc4;
    end

    if (op_q == rv64_pkg::ITEM_LOAD_DATA) begin
      nxt    = '0;
      req    = rv64_pkg::MEM_NONE;
      addr   = '0;
      bytes  = '0;
      wdata  = '0;
      stat   = rv64_pkg::ST_NORMAL;
      hc     = '0;
      md_req = 1'b0;
      lp_set = 1'b0;
      wr     = lp_q;
      wd     = ld_dest_q;
      res    = rv64_pkg::ext_load(ldata_q, ld_size_q, ld_sext_q);
    end

    if (wd == 5'd0) begin
      wr = 1'b0;
    end
  end

  assign status_o.md_req  = md_req;
  assign status_o.md_done = md_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      lp_q      <= 1'b0;
      ld_dest_q <= '0;
      ld_size_q <= '0;
      ld_sext_q <= 1'b0;
    end else begin
      if (cmd_i.commit && wr_q) begin
        valid_q[wd_q] <= 1'b1;
      end
      if (cmd_i.exec) begin
        lp_q <= lp_set;
        if (lp_set) begin
          ld_dest_q <= rd;
          ld_size_q <= f3[1:0];
          ld_sext_q <= !f3[2];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= operation_i;
      ins_q   <= instruction_i;
      pc_q    <= pc_i;
      ldata_q <= load_data_i;
      ra_q    <= ra_d;
      rb_q    <= instruction_i[24:20];
    end
    if (cmd_i.latch_ops) begin
      a_q <= valid_q[ra_q] ? rd_a : 64'd0;
      b_q <= valid_q[rb_q] ? rd_b : 64'd0;
    end
    if (cmd_i.exec) begin
      nxt_q   <= nxt;
      req_q   <= req;
      addr_q  <= addr;
      bytes_q <= bytes;
      wdata_q <= wdata;
      stat_q  <= stat;
      hc_q    <= hc;
      res_q   <= res;
      wr_q    <= wr;
      wd_q    <= wd;
    end else if (md_done) begin
      res_q <= md_res;
    end
    if (cmd_i.commit) begin
      next_pc_o        <= nxt_q;
      mem_request_o    <= req_q;
      mem_address_o    <= addr_q;
      mem_bytes_o      <= bytes_q;
      mem_write_data_o <= wdata_q;
      result_status_o  <= stat_q;
      halt_code_o      <= hc_q;
    end
  end

endmodule

@@ rtl/rv64_chk.sv @@
// Port-level checks on the execute unit, bound to the top level.
// Depends on rv64_pkg and rv64im_execute_unit.
module rv64_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] next_pc,
  input logic [1:0]  mem_request,
  input logic [3:0]  mem_bytes,
  input logic [1:0]  status,
  input logic [63:0] halt_code
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(next_pc))
    else $error("stalled result changed");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early after transfer");

  a_req_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> mem_request != 2'd3)
    else $error("bad memory request code");

  a_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == rv64_pkg::ST_ILLEGAL |->
      halt_code == '1 && mem_request == rv64_pkg::MEM_NONE && mem_bytes == 4'd0)
    else $error("illegal result not clean");

endmodule

bind rv64im_execute_unit rv64_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .next_pc     (out_ch.next_pc),
  .mem_request (out_ch.mem_request),
  .mem_bytes   (out_ch.mem_bytes),
  .status      (out_ch.status),
  .halt_code   (out_ch.halt_code)
);
